// File: design/cats_pkg.sv
`timescale 1ns / 1ps

package cats_pkg;

	localparam int TOKEN_MAX_DEF  = 16;
	localparam int DEPTH_BITS_DEF = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 5;
	localparam int POS_W      = 32;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOK_LO  = 2'd0,
		REG_TOK_HI  = 2'd1,
		REG_TOK_LEN = 2'd2,
		REG_START   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_TEXT  = 3'b001,
		MODE_LINE  = 3'b010,
		MODE_BLOCK = 3'b100
	} mode_t;

	typedef struct packed {
		logic             live;
		logic             last;
		logic             slash_cand;
		logic [POS_W-1:0] pos;
	} scan_info_t;

endpackage

// File: design/cats_scanner.sv
`timescale 1ns / 1ps

module cats_scanner import cats_pkg::*; #(
	parameter int TOKEN_MAX  = TOKEN_MAX_DEF,
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [7:0]       text_byte,
	input  logic             first_byte,
	input  logic             last_byte,
	input  logic [POS_W-1:0] start_position,
	input  logic             emit,
	output logic [7:0]       window_d [TOKEN_MAX],
	output logic             marks_d [TOKEN_MAX],
	output scan_info_t       info
);

	localparam int MARK1 = (TOKEN_MAX >= 2) ? 1 : 0;

	mode_t                 mode_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [7:0]            window_q [TOKEN_MAX];
	logic                  marks_q [TOKEN_MAX];
	logic                  pend_q;
	logic [POS_W-1:0]      count_q;
	logic                  done_q;

	mode_t                 mode_d;
	logic [DEPTH_BITS-1:0] depth_d;
	logic                  pend_d;
	logic [POS_W-1:0]      count_e;

	always_comb begin
		mode_t                 mode_e;
		logic [DEPTH_BITS-1:0] depth_e;
		logic                  pend_e;
		logic [7:0]            prev;
		logic                  consumed;
		logic                  slash_cand;

		// a new search starts from a cleared scanner
		mode_e  = first_byte ? MODE_TEXT : mode_q;
		depth_e = first_byte ? '0 : depth_q;
		pend_e  = first_byte ? 1'b0 : pend_q;
		count_e = first_byte ? '0 : count_q;
		prev    = first_byte ? 8'h00 : window_q[0];

		window_d[0] = text_byte;
		marks_d[0]  = 1'b0;
		for (int k = 1; k < TOKEN_MAX; k++) begin
			window_d[k] = first_byte ? 8'h00 : window_q[k-1];
			marks_d[k]  = first_byte ? 1'b0 : marks_q[k-1];
		end

		mode_d     = mode_e;
		depth_d    = depth_e;
		pend_d     = pend_e;
		consumed   = 1'b0;
		slash_cand = 1'b0;

		// second byte of a possible opener or closer pair
		if (pend_e) begin
			pend_d = 1'b0;
			if (mode_e == MODE_BLOCK) begin
				if (prev == CH_STAR && text_byte == CH_SLASH) begin
					consumed = 1'b1;
					if (depth_e != '0) depth_d = depth_e - DEPTH_BITS'(1);
					if (depth_d == '0) mode_d = MODE_TEXT;
				end else if (prev == CH_SLASH && text_byte == CH_STAR) begin
					consumed = 1'b1;
					if (depth_e != '1) depth_d = depth_e + DEPTH_BITS'(1);
				end
			end else if (mode_e != MODE_LINE) begin
				if (text_byte == CH_SLASH) begin
					mode_d   = MODE_LINE;
					consumed = 1'b1;
				end else if (text_byte == CH_STAR) begin
					mode_d   = MODE_BLOCK;
					depth_d  = DEPTH_BITS'(1);
					consumed = 1'b1;
				end else begin
					slash_cand = 1'b1;
					if (TOKEN_MAX >= 2) marks_d[MARK1] = 1'b1;
				end
			end
		end

		if (!consumed) begin
			unique case (mode_d)
				MODE_LINE: begin
					if (text_byte == CH_LF || text_byte == CH_CR) mode_d = MODE_TEXT;
				end
				MODE_BLOCK: begin
					if (text_byte == CH_STAR || text_byte == CH_SLASH) pend_d = 1'b1;
				end
				default: begin
					if (text_byte == CH_SLASH) pend_d = 1'b1;
					else marks_d[0] = 1'b1;
				end
			endcase
		end

		// lone slash at the end of text counts as plain text
		if (last_byte && pend_d) begin
			if (mode_d != MODE_LINE && mode_d != MODE_BLOCK) marks_d[0] = 1'b1;
			pend_d = 1'b0;
		end

		info.live       = first_byte || !done_q;
		info.last       = last_byte;
		info.slash_cand = slash_cand;
		info.pos        = start_position + count_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TEXT;
			depth_q <= '0;
			pend_q  <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
			for (int k = 0; k < TOKEN_MAX; k++) begin
				window_q[k] <= 8'h00;
				marks_q[k]  <= 1'b0;
			end
		end else if (adv && info.live) begin
			mode_q  <= mode_d;
			depth_q <= depth_d;
			pend_q  <= pend_d;
			count_q <= count_e + POS_W'(1);
			done_q  <= emit;
			for (int k = 0; k < TOKEN_MAX; k++) begin
				window_q[k] <= window_d[k];
				marks_q[k]  <= marks_d[k];
			end
		end
	end

endmodule

// File: design/cats_match.sv
`timescale 1ns / 1ps

module cats_match import cats_pkg::*; #(
	parameter int TOKEN_MAX = TOKEN_MAX_DEF
) (
	input  logic [7:0]            window_d [TOKEN_MAX],
	input  logic                  marks_d [TOKEN_MAX],
	input  scan_info_t            info,
	input  logic [CFG_DATA_W-1:0] token_bytes_low,
	input  logic [CFG_DATA_W-1:0] token_bytes_high,
	input  logic [LEN_W-1:0]      token_length,
	output logic                  emit,
	output logic                  found,
	output logic [POS_W-1:0]      match_index
);

	localparam int IDX_W = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;

	logic [7:0]       tok [TOKEN_MAX];
	logic [LEN_W-1:0] len_e;
	logic [IDX_W-1:0] sel;
	logic             hit;
	logic             slash_hit;

	always_comb begin
		for (int j = 0; j < TOKEN_MAX; j++) begin
			if (j < 8) tok[j] = token_bytes_low[8*(j%8) +: 8];
			else tok[j] = token_bytes_high[8*(j%8) +: 8];
		end
	end

	always_comb begin
		if (token_length == '0) len_e = LEN_W'(1);
		else if (token_length > LEN_W'(TOKEN_MAX)) len_e = LEN_W'(TOKEN_MAX);
		else len_e = token_length;
	end

	assign sel = IDX_W'(len_e - LEN_W'(1));

	// token byte j lines up with the window entry len-1-j
	always_comb begin
		logic [IDX_W-1:0] idx;
		hit = marks_d[sel];
		for (int j = 0; j < TOKEN_MAX; j++) begin
			idx = sel - IDX_W'(j);
			if (LEN_W'(j) < len_e && window_d[idx] != tok[j]) hit = 1'b0;
		end
	end

	assign slash_hit = info.slash_cand && len_e == LEN_W'(1) && tok[0] == CH_SLASH;

	assign found = slash_hit || hit;
	assign emit  = info.live && (found || info.last);

	always_comb begin
		if (slash_hit) match_index = info.pos - POS_W'(1);
		else if (hit) match_index = info.pos - POS_W'(len_e - LEN_W'(1));
		else match_index = '0;
	end

endmodule

// File: design/comment_aware_token_search.sv
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  tdata: text_byte, tuser: first_byte, tlast: last_byte
// m_        out        m_tvalid/m_tready  tdata: match_index, tuser: found
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// one item per cycle unless a waiting result holds a full input register; each item is
// held in the input register and its result, if any, is registered in the output register
// the window compare runs in parallel over all token bytes
// arst_n clears the scanner, both valid flags and the configuration, but the token length resets to one
// a waiting result holds the input register only once that register is full

module comment_aware_token_search import cats_pkg::*; #(
	parameter int TOKEN_MAX  = TOKEN_MAX_DEF,
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] text_byte
	input  logic                  s_tuser,   // [0] first_byte
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [POS_W-1:0]      m_tdata,   // [31:0] match_index
	output logic                  m_tuser,   // [0] found
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CFG_DATA_W-1:0] tok_lo_q;
	logic [CFG_DATA_W-1:0] tok_hi_q;
	logic [LEN_W-1:0]      tok_len_q;
	logic [POS_W-1:0]      start_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	logic             m_valid_q;
	logic             found_q;
	logic [POS_W-1:0] index_q;

	logic             out_free;
	logic             adv;
	logic [7:0]       window_d [TOKEN_MAX];
	logic             marks_d [TOKEN_MAX];
	scan_info_t       info;
	logic             emit;
	logic             found;
	logic [POS_W-1:0] match_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_lo_q  <= '0;
			tok_hi_q  <= '0;
			tok_len_q <= LEN_W'(1);
			start_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TOK_LO:  tok_lo_q  <= cfg_data;
				REG_TOK_HI:  tok_hi_q  <= cfg_data;
				REG_TOK_LEN: tok_len_q <= cfg_data[LEN_W-1:0];
				REG_START:   start_q   <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !m_valid_q || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	cats_scanner #(
		.TOKEN_MAX  (TOKEN_MAX),
		.DEPTH_BITS (DEPTH_BITS)
	) u_scanner (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.text_byte      (byte_s1),
		.first_byte     (first_s1),
		.last_byte      (last_s1),
		.start_position (start_q),
		.emit           (emit),
		.window_d       (window_d),
		.marks_d        (marks_d),
		.info           (info)
	);

	cats_match #(
		.TOKEN_MAX (TOKEN_MAX)
	) u_match (
		.window_d         (window_d),
		.marks_d          (marks_d),
		.info             (info),
		.token_bytes_low  (tok_lo_q),
		.token_bytes_high (tok_hi_q),
		.token_length     (tok_len_q),
		.emit             (emit),
		.found            (found),
		.match_index      (match_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			found_q <= found;
			index_q <= match_index;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = index_q;
	assign m_tuser  = found_q;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cats_pkg::*;

	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_ITEMS   = 300;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] index;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // [7:0] text_byte
	logic                  s_tuser = 1'b0; // [0] first_byte
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [POS_W-1:0]      m_tdata;        // [31:0] match_index
	logic                  m_tuser;        // [0] found
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the block's registers
	logic [63:0]      tok_lo = '0;
	logic [63:0]      tok_hi = '0;
	logic [LEN_W-1:0] tok_len = 5'd1;
	logic [POS_W-1:0] start_pos = '0;

	// shadow of the scanner
	mode_t                           scan_mode;
	logic [DEPTH_BITS_DEF-1:0]       nest_depth;
	logic [TOKEN_MAX_DEF-1:0][7:0]   win;
	logic [TOKEN_MAX_DEF-1:0]        marks;
	logic                            pend_slash;
	logic [POS_W-1:0]                byte_count;
	logic                            search_done;

	outcome_t outcomes[$];
	int       sent_items = 0;
	int       fail_count = 0;
	bit       idle_on = 1'b1;
	int       stall_left = 0;
	int       quiet = 0;

	comment_aware_token_search uut (.*);

	always #5 clk = ~clk;

	function automatic logic [7:0] token_char(input int j);
		return (j < 8) ? tok_lo[8*j +: 8] : tok_hi[8*(j-8) +: 8];
	endfunction

	function automatic int token_span();
		if (tok_len == 0)
			return 1;
		if (tok_len > TOKEN_MAX_DEF)
			return TOKEN_MAX_DEF;
		return int'(tok_len);
	endfunction

	function automatic void clear_scanner();
		scan_mode   = MODE_TEXT;
		nest_depth  = '0;
		win         = '0;
		marks       = '0;
		pend_slash  = 1'b0;
		byte_count  = '0;
		search_done = 1'b0;
	endfunction

	// advance the shadow scanner by one byte and queue the outcome it yields
	function automatic void scan_byte(input logic [7:0] c, input logic first, input logic last);
		logic [7:0]       prev;
		logic             consumed;
		logic             slash_cand;
		logic             hit;
		logic [POS_W-1:0] pos;
		int               len;
		int               j;
		outcome_t         res;
		consumed   = 1'b0;
		slash_cand = 1'b0;
		if (first)
			clear_scanner();
		if (search_done)
			return;
		prev  = win[0];
		win   = {win[TOKEN_MAX_DEF-2:0], c};
		marks = {marks[TOKEN_MAX_DEF-2:0], 1'b0};
		if (pend_slash) begin
			pend_slash = 1'b0;
			if (scan_mode == MODE_BLOCK) begin
				if (prev == CH_STAR && c == CH_SLASH) begin
					consumed = 1'b1;
					if (nest_depth != 0)
						nest_depth--;
					if (nest_depth == 0)
						scan_mode = MODE_TEXT;
				end else if (prev == CH_SLASH && c == CH_STAR) begin
					consumed = 1'b1;
					if (nest_depth != '1)
						nest_depth++;
				end
			end else if (scan_mode != MODE_LINE) begin
				if (c == CH_SLASH) begin
					scan_mode = MODE_LINE;
					consumed  = 1'b1;
				end else if (c == CH_STAR) begin
					scan_mode  = MODE_BLOCK;
					nest_depth = DEPTH_BITS_DEF'(1);
					consumed   = 1'b1;
				end else begin
					// the held slash turns out to be plain text
					slash_cand = 1'b1;
					marks[1]   = 1'b1;
				end
			end
		end
		if (!consumed) begin
			case (scan_mode)
				MODE_LINE: begin
					if (c == CH_LF || c == CH_CR)
						scan_mode = MODE_TEXT;
				end
				MODE_BLOCK: begin
					if (c == CH_STAR || c == CH_SLASH)
						pend_slash = 1'b1;
				end
				default: begin
					if (c == CH_SLASH)
						pend_slash = 1'b1;
					else
						marks[0] = 1'b1;
				end
			endcase
		end
		if (last && pend_slash) begin
			if (scan_mode == MODE_TEXT)
				marks[0] = 1'b1;
			pend_slash = 1'b0;
		end
		pos = start_pos + byte_count;
		byte_count++;
		len = token_span();
		if (slash_cand && len == 1 && token_char(0) == CH_SLASH) begin
			res.found   = 1'b1;
			res.index   = pos - 1;
			search_done = 1'b1;
			outcomes.push_back(res);
			return;
		end
		hit = marks[len-1];
		for (j = 0; j < len; j++)
			if (win[len-1-j] != token_char(j))
				hit = 1'b0;
		if (hit || last) begin
			res.found   = hit;
			res.index   = hit ? pos - (len - 1) : '0;
			search_done = 1'b1;
			outcomes.push_back(res);
		end
	endfunction

	function automatic logic [127:0] pack_token(input string s);
		logic [127:0] v;
		int           i;
		v = '0;
		for (i = 0; i < s.len(); i++)
			v[8*i +: 8] = s[i];
		return v;
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 6))
			0: return CH_SLASH;
			1: return CH_STAR;
			2: return "a";
			3: return "b";
			4: return token_char($urandom_range(0, token_span() - 1));
			5: return "c";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// builds one search; returns 1 when it is raw noise with random flags
	function automatic bit compose_text(output logic [7:0] text[$]);
		int k;
		int n;
		text = {};
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 30))
				text.push_back(8'($urandom_range(0, 255)));
			return 1'b1;
		end
		repeat ($urandom_range(2, 12)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: text.push_back(pick_char());
				3: begin
					for (k = 0; k < token_span(); k++)
						text.push_back(token_char(k));
				end
				4: begin
					text.push_back(CH_SLASH);
					text.push_back(CH_SLASH);
					repeat ($urandom_range(0, 4))
						text.push_back(pick_char());
					text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
				end
				5: begin
					text.push_back(CH_SLASH);
					text.push_back(CH_STAR);
					repeat ($urandom_range(0, 5))
						text.push_back(pick_char());
					if ($urandom_range(0, 2) == 0) begin
						// one nested level with the token inside
						text.push_back(CH_SLASH);
						text.push_back(CH_STAR);
						for (k = 0; k < token_span(); k++)
							text.push_back(token_char(k));
						text.push_back(CH_STAR);
						text.push_back(CH_SLASH);
					end
					text.push_back(CH_STAR);
					text.push_back(CH_SLASH);
				end
				6: begin
					n = $urandom_range(1, token_span());
					for (k = 0; k < n; k++)
						text.push_back(token_char(k));
				end
				7: text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
				default: text.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic first, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16))
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= first;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_items++;
		scan_byte(c, first, last);
	endtask

	task automatic send_text(input logic [7:0] text[$]);
		foreach (text[i])
			send_byte(text[i], i == 0, i == text.size() - 1);
	endtask

	task automatic send_string(input string s);
		logic [7:0] text[$];
		int         i;
		text = {};
		for (i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		send_text(text);
	endtask

	// stop sending, let every outcome arrive and the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (outcomes.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TOK_LO:  tok_lo = value;
			REG_TOK_HI:  tok_hi = value;
			REG_TOK_LEN: tok_len = value[LEN_W-1:0];
			REG_START:   start_pos = value[POS_W-1:0];
		endcase
	endtask

	task automatic program_search(input logic [127:0] chars, input logic [63:0] len_word,
		input logic [63:0] start_word);
		settle();
		write_reg(REG_TOK_LO, chars[63:0]);
		write_reg(REG_TOK_HI, chars[127:64]);
		write_reg(REG_TOK_LEN, len_word);
		write_reg(REG_START, start_word);
	endtask

	task automatic test_reset_defaults();
		logic [7:0] text[$];
		// token after reset is one zero byte
		text = {8'hFF, 8'h00};
		send_text(text);
	endtask

	task automatic test_line_comment_wrap();
		program_search(pack_token("ab"), 64'd2, 64'hFFFF_FFFF);
		send_string("//ab\rab");
	endtask

	task automatic test_nested_block();
		program_search(pack_token("q"), 64'd1, 64'd0);
		send_string("/*/*q*/q*/q");
	endtask

	task automatic test_slash_cases();
		// zero length acts as one
		program_search(pack_token("/"), 64'd0, 64'd0);
		send_string("a/");
		send_string("/b");
		program_search(pack_token("//"), 64'd2, 64'd0);
		send_string("//");
	endtask

	task automatic test_short_tail();
		program_search(pack_token("xyz"), 64'd3, 64'd7);
		send_string("xy");
		// search is over, this byte must be dropped
		send_byte("z", 1'b0, 1'b1);
	endtask

	task automatic test_config_mid_search();
		program_search(pack_token("k"), 64'd1, 64'd0);
		send_byte("a", 1'b1, 1'b0);
		settle();
		write_reg(REG_TOK_LO, 64'(pack_token("a")));
		write_reg(REG_START, 64'd100);
		send_byte("a", 1'b0, 1'b1);
	endtask

	task automatic test_depth_limit();
		logic [7:0] text[$];
		text = {};
		program_search(pack_token("q"), 64'd1, 64'd0);
		// open past the depth ceiling, then close one level short of plain text
		repeat ((1 << DEPTH_BITS_DEF) + 1)
			text = {text, CH_SLASH, CH_STAR};
		repeat ((1 << DEPTH_BITS_DEF) - 2)
			text = {text, CH_STAR, CH_SLASH};
		text = {text, 8'("q"), CH_STAR, CH_SLASH, 8'("q")};
		send_text(text);
	endtask

	task automatic test_random();
		int           target;
		int           k;
		logic [127:0] chars;
		logic [63:0]  len_word;
		logic [63:0]  start_word;
		logic [7:0]   text[$];
		target = sent_items + RANDOM_ITEMS;
		while (sent_items < target) begin
			for (k = 0; k < 16; k++)
				chars[8*k +: 8] = pick_char();
			if ($urandom_range(0, 5) == 0)
				chars = {$urandom, $urandom, $urandom, $urandom};
			case ($urandom_range(0, 9))
				0: len_word = 64'd16;
				1: len_word = 64'($urandom_range(17, 31));
				2: len_word = 64'd0;
				default: len_word = 64'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 3))
				0: start_word = 64'd0;
				1: start_word = 64'hFFFF_FFFF - 64'($urandom_range(0, 40));
				default: start_word = 64'($urandom);
			endcase
			// bits above the register width are dropped by the block
			if ($urandom_range(0, 3) == 0) begin
				len_word[63:32]   = $urandom;
				start_word[63:32] = $urandom;
			end
			program_search(chars, len_word, start_word);
			idle_on = (target - sent_items > CALM_ITEMS) && ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 8)) begin
				if (compose_text(text)) begin
					foreach (text[i])
						send_byte(text[i], $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
				end else begin
					send_text(text);
				end
			end
		end
	endtask

	// result side: random stalls and the in-order check
	always @(posedge clk) begin
		outcome_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (outcomes.size() == 0) begin
					if (fail_count < 40)
						$display("%0t unexpected result: expected none actual found=%0b index=%0h",
							$time, m_tuser, m_tdata);
					fail_count++;
				end else begin
					want = outcomes.pop_front();
					if (m_tuser !== want.found) begin
						if (fail_count < 40)
							$display("%0t found mismatch: expected %0b actual %0b",
								$time, want.found, m_tuser);
						fail_count++;
					end
					if (m_tdata !== want.index) begin
						if (fail_count < 40)
							$display("%0t match_index mismatch: expected %0h actual %0h",
								$time, want.index, m_tdata);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 15);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		clear_scanner();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_line_comment_wrap();
		test_nested_block();
		test_slash_cases();
		test_short_tail();
		test_config_mid_search();
		test_depth_limit();
		test_random();
		settle();
		repeat (8)
			@(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
